FILE: rtl/timestamped_playout_buffer_defines.svh
// assertion macros for the playout buffer
// no dependencies
`ifndef TIMESTAMPED_PLAYOUT_BUFFER_DEFINES_SVH
`define TIMESTAMPED_PLAYOUT_BUFFER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TPB_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("tpb check failed");
// implication with the consequent checked in the next cycle
`define TPB_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("tpb check failed");
`endif

FILE: rtl/tpb_pkg.sv
// package for the playout buffer: request codes, status codes, item types
// no dependencies
package tpb_pkg;
	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_SEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNDERRUN = 2'd1,
		ST_DROPPED  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] time_value;
		logic [7:0]  data_byte;
		logic        chunk_end;
	} in_item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        is_silence;
		logic [1:0]  status;
		logic [31:0] play_position;
		logic [31:0] stream_length;
	} out_item_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_EVAL,
		EX_RDWAIT,
		EX_SEEK,
		EX_DONE
	} ex_state_t;
endpackage

FILE: rtl/timestamped_playout_buffer.sv
// top level of the time-stamped pcm playout buffer
// depends on tpb_pkg, tpb_queue, tpb_engine and the defines header
//
// Playout buffer for time-stamped pcm chunks. Items enter through a two-entry
// input queue (push/full) and results leave through a two-entry result queue
// (empty/pop), one result per item, in order. The engine works on one item at
// a time: a push, a clear or a backward seek is evaluated and done, a read
// repeats its evaluation for each stale chunk or stale stretch it skips, and a
// forward seek drops chunks in its seek state until the target is reached. A
// full result queue holds the engine in its done state. The byte store is a
// single ram with a registered read port, which is why a read that returns a
// stored byte passes through a wait state. No clearing pass is needed.
`include "timestamped_playout_buffer_defines.svh"
module timestamped_playout_buffer #(
	parameter int STORE_BYTES = 4096,
	parameter int MAX_CHUNKS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tpb_pkg::in_item_t   in_item,
	output logic                full,
	input  logic                pop,
	output tpb_pkg::out_item_t  out_item,
	output logic                empty
);
	import tpb_pkg::*;

	// front: input queue
	in_item_t  fq_item;
	logic      fq_empty;
	logic      fq_pop;
	// back: engine results into result queue
	out_item_t eng_res;
	logic      eng_valid;
	logic      rq_full;

	tpb_queue #(.WIDTH($bits(in_item_t))) u_inq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_item),
		.full   (full),
		.pop    (fq_pop),
		.dout   (fq_item),
		.empty  (fq_empty)
	);

	tpb_engine #(.STORE_BYTES(STORE_BYTES), .MAX_CHUNKS(MAX_CHUNKS)) u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (!fq_empty),
		.req       (fq_item),
		.req_take  (fq_pop),
		.res_valid (eng_valid),
		.res       (eng_res),
		.res_full  (rq_full)
	);

	tpb_queue #(.WIDTH($bits(out_item_t))) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (eng_valid),
		.din    (eng_res),
		.full   (rq_full),
		.pop    (pop),
		.dout   (out_item),
		.empty  (empty)
	);

	`TPB_ASSERT_IMP(a_underrun_no_byte, !empty && out_item.status == ST_UNDERRUN,
		!out_item.byte_valid)
	`TPB_ASSERT_IMP(a_silence_zero, !empty && out_item.is_silence,
		out_item.out_byte == 8'd0 && out_item.byte_valid)
	`TPB_ASSERT_IMP(a_take_needs_item, fq_pop, !fq_empty)
endmodule

FILE: rtl/tpb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/tpb_queue.sv
// two-entry item queue used between front and back and on the result side
// depends on nothing beyond its parameter
module tpb_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	logic [WIDTH-1:0] slot_q [2];
	logic             rd_q;
	logic             wr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

FILE: rtl/tpb_engine.sv
// back end: carries out push, read, seek and clear on the chunk store
// depends on tpb_pkg and tpb_ram
module tpb_engine #(
	parameter int STORE_BYTES = 4096,
	parameter int MAX_CHUNKS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  tpb_pkg::in_item_t req,
	output logic              req_take,
	output logic              res_valid,
	output tpb_pkg::out_item_t res,
	input  logic              res_full
);
	import tpb_pkg::*;

	localparam int SW = $clog2(STORE_BYTES);
	localparam int CW = $clog2(MAX_CHUNKS);
	// ring of descriptor slots, indexes wrap at a power of two
	localparam int DN = 1 << CW;

	// descriptor ring held in flops, MAX_CHUNKS rounded up to a power of two
	logic [31:0]   dtime_q  [DN];
	logic [SW-1:0] dstart_q [DN];
	logic [SW:0]   dlen_q   [DN];

	logic [CW-1:0] head_q;
	logic [CW:0]   count_q;
	logic [SW-1:0] wptr_q;
	logic [SW:0]   used_q;
	logic          open_q;
	logic [31:0]   pos_q;
	logic [SW:0]   foff_q;

	ex_state_t     st_q, st_d;
	in_item_t      cur_q;
	out_item_t     res_q;

	logic          we;
	logic [SW-1:0] raddr;
	logic [7:0]    rdata;

	logic [CW-1:0] tail;
	logic [CW-1:0] last_idx;
	logic [32:0]   itime;
	logic [32:0]   f_end;
	logic [32:0]   diff;
	logic [SW:0]   rest;
	logic [SW:0]   f_len;
	logic [SW-1:0] f_start;
	logic [31:0]   f_time;
	logic          store_full;
	logic          desc_full;
	logic [SW:0]   cut;
	logic [SW:0]   sum_addr;

	assign tail     = head_q + count_q[CW-1:0];
	assign last_idx = head_q + count_q[CW-1:0] - CW'(1);
	assign f_len    = dlen_q[head_q];
	assign f_start  = dstart_q[head_q];
	assign f_time   = dtime_q[head_q];
	assign itime    = {1'b0, f_time} + 33'(foff_q);
	assign f_end    = {1'b0, f_time} + 33'(f_len);
	assign diff     = {1'b0, pos_q} - itime;
	assign rest     = f_len - foff_q;
	assign store_full = (used_q >= (SW+1)'(STORE_BYTES));
	assign desc_full  = (count_q >= (CW+1)'(MAX_CHUNKS));
	assign cut      = (SW+1)'(cur_q.time_value - f_time);
	assign sum_addr = {1'b0, f_start} + foff_q;

	assign we    = (st_q == EX_EVAL) && (cur_q.req_type == REQ_PUSH)
		&& !(desc_full && !open_q) && !store_full;
	assign raddr = (sum_addr >= (SW+1)'(STORE_BYTES))
		? SW'(sum_addr - (SW+1)'(STORE_BYTES)) : SW'(sum_addr);

	tpb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (wptr_q),
		.wdata (cur_q.data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_take  = (st_q == EX_IDLE) && req_valid;
	assign res_valid = (st_q == EX_DONE);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE:   if (req_valid) st_d = EX_EVAL;
			EX_EVAL: begin
				unique case (cur_q.req_type)
					REQ_READ: begin
						if (count_q == '0) st_d = EX_DONE;
						else if ({1'b0, pos_q} < itime) st_d = EX_DONE;
						else if (itime < {1'b0, pos_q}) st_d = EX_EVAL;
						else st_d = EX_RDWAIT;
					end
					REQ_SEEK: begin
						if (cur_q.time_value == pos_q || cur_q.time_value < pos_q)
							st_d = EX_DONE;
						else st_d = EX_SEEK;
					end
					default: st_d = EX_DONE;
				endcase
			end
			EX_RDWAIT: st_d = EX_DONE;
			EX_SEEK: begin
				if (count_q == '0) st_d = EX_DONE;
				else if ({1'b0, f_time} <= {1'b0, cur_q.time_value}
					&& {1'b0, cur_q.time_value} < f_end) st_d = EX_DONE;
			end
			EX_DONE:   if (!res_full) st_d = EX_IDLE;
			default:   st_d = EX_IDLE;
		endcase
	end

	// drop front chunk helper values
	logic [SW:0] used_drop;
	assign used_drop = (f_len <= used_q) ? used_q - f_len : '0;

	always_ff @(posedge clk) begin
		if (req_take) begin
			cur_q <= req;
		end
		if (st_q == EX_EVAL && cur_q.req_type == REQ_PUSH && we && !open_q) begin
			dtime_q[tail]  <= cur_q.time_value;
			dstart_q[tail] <= wptr_q;
			dlen_q[tail]   <= (SW+1)'(1);
		end else if (we) begin
			dlen_q[tail] <= dlen_q[tail] + (SW+1)'(1);
		end
		if (st_q == EX_SEEK && count_q != '0
			&& {1'b0, f_time} <= {1'b0, cur_q.time_value}
			&& {1'b0, cur_q.time_value} < f_end) begin
			dstart_q[head_q] <= ({1'b0, f_start} + cut >= (SW+1)'(STORE_BYTES))
				? SW'({1'b0, f_start} + cut - (SW+1)'(STORE_BYTES))
				: SW'({1'b0, f_start} + cut);
			dlen_q[head_q]   <= f_len - cut;
			dtime_q[head_q]  <= cur_q.time_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= EX_IDLE;
			head_q  <= '0;
			count_q <= '0;
			wptr_q  <= '0;
			used_q  <= '0;
			open_q  <= 1'b0;
			pos_q   <= '0;
			foff_q  <= '0;
			res_q   <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == EX_IDLE && req_valid) begin
				res_q <= '0;
			end
			unique case (st_q)
				EX_EVAL: begin
					unique case (cur_q.req_type)
						REQ_PUSH: begin
							if (we) begin
								wptr_q <= (wptr_q == SW'(STORE_BYTES - 1))
									? '0 : wptr_q + SW'(1);
								used_q <= used_q + (SW+1)'(1);
							end else begin
								res_q.status <= ST_DROPPED;
							end
							if (cur_q.chunk_end && (open_q || we)) begin
								open_q  <= 1'b0;
								count_q <= count_q + (CW+1)'(1);
							end else if (we) begin
								open_q <= 1'b1;
							end
						end
						REQ_READ: begin
							if (count_q == '0) begin
								foff_q       <= '0;
								res_q.status <= ST_UNDERRUN;
							end else if ({1'b0, pos_q} < itime) begin
								res_q.byte_valid <= 1'b1;
								res_q.is_silence <= 1'b1;
								pos_q            <= pos_q + 32'd1;
							end else if (itime < {1'b0, pos_q}) begin
								if (33'(rest) <= diff) begin
									used_q  <= used_drop;
									head_q  <= head_q + CW'(1);
									count_q <= count_q - (CW+1)'(1);
									foff_q  <= '0;
								end else begin
									foff_q <= foff_q + (SW+1)'(diff);
								end
							end
						end
						REQ_SEEK: begin
							if (cur_q.time_value < pos_q) begin
								count_q <= '0;
								open_q  <= 1'b0;
								used_q  <= '0;
								foff_q  <= '0;
								pos_q   <= cur_q.time_value;
							end
						end
						default: begin
							count_q <= '0;
							open_q  <= 1'b0;
							used_q  <= '0;
							foff_q  <= '0;
							pos_q   <= '0;
						end
					endcase
				end
				EX_RDWAIT: begin
					res_q.byte_valid <= 1'b1;
					res_q.out_byte   <= rdata;
					pos_q            <= pos_q + 32'd1;
					if (foff_q + (SW+1)'(1) >= f_len) begin
						used_q  <= used_drop;
						head_q  <= head_q + CW'(1);
						count_q <= count_q - (CW+1)'(1);
						foff_q  <= '0;
					end else begin
						foff_q <= foff_q + (SW+1)'(1);
					end
				end
				EX_SEEK: begin
					if (count_q == '0) begin
						pos_q  <= cur_q.time_value;
						foff_q <= '0;
					end else if ({1'b0, f_time} <= {1'b0, cur_q.time_value}
						&& {1'b0, cur_q.time_value} < f_end) begin
						used_q <= (cut <= used_q) ? used_q - cut : '0;
						pos_q  <= cur_q.time_value;
						foff_q <= '0;
					end else begin
						used_q  <= used_drop;
						head_q  <= head_q + CW'(1);
						count_q <= count_q - (CW+1)'(1);
						foff_q  <= '0;
					end
				end
				default: begin
				end
			endcase
			if (st_d == EX_DONE && st_q != EX_DONE) begin
				res_q.play_position <= '0;
			end
		end
	end

	// position and length are formed from settled state at the result
	logic [32:0] len_sum;
	assign len_sum = {1'b0, dtime_q[last_idx]} + 33'(dlen_q[last_idx]);
	always_comb begin
		res = res_q;
		res.play_position = pos_q;
		res.stream_length = (count_q == '0) ? pos_q : len_sum[31:0];
	end
endmodule

FILE: test/timestamped_playout_buffer_tb.sv
// testbench for the time-stamped pcm playout buffer: directed and random items,
// every result checked against a cycle-free behavioral predictor
// depends on tpb_pkg and timestamped_playout_buffer
module timestamped_playout_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpb_pkg::*;

	localparam int STORE_BYTES = 4096;
	localparam int MAX_CHUNKS  = 16;
	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEMS       = 1000;

	logic clk;
	logic arst_n;
	logic push;
	in_item_t in_item;
	logic full;
	logic pop;
	out_item_t out_item;
	logic empty;

	timestamped_playout_buffer #(
		.STORE_BYTES(STORE_BYTES),
		.MAX_CHUNKS(MAX_CHUNKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_item(in_item),
		.full(full),
		.pop(pop),
		.out_item(out_item),
		.empty(empty)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state, a private copy of the buffer contents
	logic [7:0]  pcm_mem [STORE_BYTES];
	logic [31:0] chunk_time [MAX_CHUNKS];
	logic [31:0] chunk_base [MAX_CHUNKS];
	logic [31:0] chunk_len [MAX_CHUNKS];
	int unsigned head_idx, closed_cnt, wr_ptr, bytes_used;
	bit chunk_open;
	logic [31:0] play_pos;
	int unsigned consumed;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int fail_count;
	int idle_cycles;
	int queued_total;

	function automatic int unsigned wrap_add(int unsigned a, int unsigned b, int unsigned n);
		longint unsigned s;
		s = longint'(a) + b;
		return int'(s % n);
	endfunction

	function automatic void drop_head();
		bytes_used = (chunk_len[head_idx] <= bytes_used) ?
			bytes_used - chunk_len[head_idx] : 0;
		head_idx = wrap_add(head_idx, 1, MAX_CHUNKS);
		closed_cnt--;
		consumed = 0;
	endfunction

	function automatic void flush_all();
		closed_cnt = 0;
		chunk_open = 0;
		bytes_used = 0;
		consumed = 0;
	endfunction

	function automatic logic [31:0] stream_end();
		int unsigned last;
		if (closed_cnt == 0)
			return play_pos;
		last = wrap_add(head_idx, closed_cnt - 1, MAX_CHUNKS);
		return chunk_time[last] + chunk_len[last];
	endfunction

	// apply one item to the predictor and return the result it produces
	function automatic out_item_t playout_step(in_item_t it);
		out_item_t r;
		int unsigned slot, f, cut;
		longint unsigned item_t, pos, rest, gap, first, stop;
		r = '0;
		case (req_t'(it.req_type))
			REQ_PUSH: begin
				slot = wrap_add(head_idx, closed_cnt, MAX_CHUNKS);
				if ((!chunk_open && closed_cnt >= MAX_CHUNKS) || bytes_used >= STORE_BYTES) begin
					r.status = ST_DROPPED;
				end else begin
					if (!chunk_open) begin
						chunk_time[slot] = it.time_value;
						chunk_base[slot] = wr_ptr;
						chunk_len[slot] = 0;
						chunk_open = 1;
					end
					pcm_mem[wr_ptr] = it.data_byte;
					wr_ptr = wrap_add(wr_ptr, 1, STORE_BYTES);
					bytes_used++;
					chunk_len[slot]++;
				end
				if (it.chunk_end && chunk_open) begin
					chunk_open = 0;
					closed_cnt++;
				end
			end
			REQ_READ: begin
				forever begin
					if (closed_cnt == 0) begin
						consumed = 0;
						r.status = ST_UNDERRUN;
						break;
					end
					f = head_idx;
					pos = play_pos;
					item_t = longint'(chunk_time[f]) + consumed;
					if (pos < item_t) begin
						r.byte_valid = 1;
						r.is_silence = 1;
						play_pos++;
						break;
					end
					if (item_t < pos) begin
						gap = pos - item_t;
						rest = longint'(chunk_len[f]) - consumed;
						if (rest <= gap)
							drop_head();
						else
							consumed += int'(gap);
						continue;
					end
					r.byte_valid = 1;
					r.out_byte = pcm_mem[wrap_add(chunk_base[f], consumed, STORE_BYTES)];
					play_pos++;
					consumed++;
					if (consumed >= chunk_len[f])
						drop_head();
					break;
				end
			end
			REQ_SEEK: begin
				if (it.time_value != play_pos) begin
					if (it.time_value < play_pos) begin
						flush_all();
					end else begin
						while (closed_cnt > 0) begin
							f = head_idx;
							first = chunk_time[f];
							stop = first + chunk_len[f];
							if (first <= it.time_value && it.time_value < stop) begin
								cut = int'(it.time_value - first);
								chunk_base[f] = wrap_add(chunk_base[f], cut, STORE_BYTES);
								chunk_len[f] -= cut;
								bytes_used = (cut <= bytes_used) ? bytes_used - cut : 0;
								chunk_time[f] = it.time_value;
								break;
							end
							drop_head();
						end
					end
					play_pos = it.time_value;
					consumed = 0;
				end
			end
			default: begin
				flush_all();
				play_pos = 0;
			end
		endcase
		r.play_position = play_pos;
		r.stream_length = stream_end();
		return r;
	endfunction

	function automatic in_item_t make_item(req_t rq, logic [31:0] tv, logic [7:0] b, logic e);
		in_item_t it;
		it.req_type = rq;
		it.time_value = tv;
		it.data_byte = b;
		it.chunk_end = e;
		return it;
	endfunction

	// append one item to the stimulus queue
	function automatic void queue_item(in_item_t it);
		pending_items.insert(pending_items.size(), it);
		queued_total++;
	endfunction

	// rough play position for steering random times near the live window
	function automatic logic [31:0] play_pos_hint();
		return play_pos;
	endfunction

	// queue a whole chunk of n bytes starting at time t
	task automatic add_chunk(logic [31:0] t, int n);
		for (int i = 0; i < n; i++)
			queue_item(make_item(REQ_PUSH, (i == 0) ? t : $urandom(),
				8'($urandom_range(255)), i == n - 1));
	endtask

	// driver: bursts of pushes with random gaps, inputs change on the falling edge
	int burst_left, gap_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (pending_items.size() == 0) begin
				push <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				in_item <= pending_items[0];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(30);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
				end
			end
		end
	end

	// receiver pops on its own pattern: a run of pops, then pops at random with stalls
	int stall_phase;
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			stall_phase = (stall_phase + 1) % 64;
			if (stall_phase < 24)
				pop <= 1'b1;
			else
				pop <= ($urandom_range(2) != 0);
		end
	end

	// monitor: accepted items and results sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (push && !full) begin
				expected_results.insert(expected_results.size(), playout_step(in_item));
				pending_items.delete(0);
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, got %p", $realtime, out_item);
					fail_count++;
				end else if (out_item !== expected_results[0]) begin
					$display("%0t: mismatch, expected %p, got %p", $realtime,
						expected_results[0], out_item);
					fail_count++;
					expected_results.delete(0);
				end else begin
					expected_results.delete(0);
				end
			end
		end
	end

	initial begin
		logic [31:0] t;
		int n;
		push = 1'b0;
		pop = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		head_idx = 0; closed_cnt = 0; wr_ptr = 0; bytes_used = 0;
		chunk_open = 0; play_pos = 0; consumed = 0;
		fail_count = 0; idle_cycles = 0; burst_left = 0; gap_left = 0;
		stall_phase = 0; queued_total = 0;

		// directed: underrun, chunk in the future, extremes of fields
		queue_item(make_item(REQ_READ, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		queue_item(make_item(REQ_PUSH, 32'd2, 8'h00, 1'b0));
		queue_item(make_item(REQ_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		for (int i = 0; i < 4; i++)
			queue_item(make_item(REQ_READ, '0, '0, 1'b0));
		// seek to current, forward into a chunk, backward
		add_chunk(32'd10, 4);
		queue_item(make_item(REQ_SEEK, 32'd4, '0, 1'b0));
		queue_item(make_item(REQ_SEEK, 32'd12, '0, 1'b0));
		queue_item(make_item(REQ_READ, '0, '0, 1'b0));
		queue_item(make_item(REQ_SEEK, 32'd1, '0, 1'b0));
		// stale data skipped on read, open chunk dropped by clear
		add_chunk(32'd0, 3);
		queue_item(make_item(REQ_PUSH, 32'd50, 8'h5A, 1'b0));
		queue_item(make_item(REQ_READ, '0, '0, 1'b0));
		queue_item(make_item(REQ_CLEAR, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		// end time past 2^32 and position wrap
		queue_item(make_item(REQ_SEEK, 32'hFFFF_FFFE, '0, 1'b0));
		add_chunk(32'hFFFF_FFFE, 3);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// random: mostly well-formed chunk streams with reads, some noise
		while (queued_total < ITEMS) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: begin
					n = ($urandom_range(15) == 0) ? $urandom_range(300, 600) : $urandom_range(1, 8);
					if (n > ITEMS - queued_total)
						n = ITEMS - queued_total;
					t = play_pos_hint() + $urandom_range(12) - 3;
					add_chunk(t, n);
				end
				5: queue_item(make_item(REQ_PUSH, $urandom(),
					8'($urandom_range(255)), 1'($urandom_range(1))));
				6: queue_item(make_item(REQ_SEEK,
					play_pos_hint() + $urandom_range(20) - 5, '0, 1'b0));
				7: queue_item(make_item(($urandom_range(7) == 0) ? REQ_CLEAR
					: REQ_SEEK, $urandom(), 8'($urandom_range(255)),
					1'($urandom_range(1))));
				default: queue_item(make_item(REQ_READ, $urandom(),
					8'($urandom_range(255)), 1'($urandom_range(1))));
			endcase
			if (pending_items.size() > 200)
				wait (pending_items.size() < 50);
		end

		while ((pending_items.size() > 0 || expected_results.size() > 0) &&
				idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			repeat (40) @(posedge clk);
			if (fail_count == 0 && expected_results.size() == 0)
				$display("*** PASSED ***");
			else
				$display("*** FAILED ***");
			$finish;
		end
	end
endmodule
